@@ rtl/llxy_pkg.sv @@
// Shared types, constants and the arc tangent table for the lat/lon to local XY projection.
package llxy_pkg;

  // Saturation limits, degrees * 1e7
  localparam logic signed [30:0] LAT_MAX = 31'sd900000000;
  localparam logic signed [31:0] LON_MAX = 32'sd1800000000;

  // mm per 1e-7 degree on a 6378137 m sphere, Q36 (pi truncated to Q36 first)
  localparam logic [63:0] MM_PER_UNIT_Q36 =
    (64'h0000_0032_43F6_A888 * 64'd6378137 + 64'd900000) / 64'd1800000;
  localparam logic [19:0] MM_LO = MM_PER_UNIT_Q36[19:0];
  localparam logic [19:0] MM_HI = MM_PER_UNIT_Q36[39:20];

  // half the radians per 1e-7 degree, Q62 (pi truncated to Q62 first)
  localparam logic [63:0] RAD_Q62_W =
    (64'hC90F_DAA2_2168_C234 + 64'd1800000000) / 64'd3600000000;
  localparam logic [31:0] RAD_Q62 = RAD_Q62_W[31:0];

  localparam logic signed [31:0] CORDIC_GAIN_Q30 = 32'sd652032874;
  localparam logic [30:0]        ONE_Q30         = 31'd1073741824;

  // atan(2^-i), Q30, truncated (entries 27 to 30 rounded up)
  localparam logic [29:0] ATAN_Q30 [32] = '{
    30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
    30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
    30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535, 30'd32767,
    30'd16383, 30'd8191, 30'd4095, 30'd2047, 30'd1023, 30'd511, 30'd255,
    30'd127, 30'd63, 30'd31, 30'd15, 30'd8, 30'd4, 30'd2, 30'd1, 30'd0
  };

  typedef struct packed {
    logic signed [30:0] latitude_e7;
    logic signed [31:0] longitude_e7;
  } in_t;

  typedef struct packed {
    logic signed [36:0] east_mm;
    logic signed [35:0] north_mm;
    logic               is_origin_fix;
  } out_t;

  // Values that ride alongside the rotation
  typedef struct packed {
    logic        is_origin;
    logic        north_neg;
    logic [34:0] north_mag;
    logic        east_neg;
    logic [43:0] east_p;     // |dlon| in mm, Q8
  } side_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    side_t              side;
  } cordic_t;

endpackage

@@ rtl/latlon_to_local_xy_projection.sv @@
// Top level: GPS fix to local east/north offsets in millimetres.
//
// Usage
//   in_*  : one request per GPS fix, latitude and longitude in degrees * 1e7.
//           A request is taken on a rising edge with in_valid high and in_stall low.
//   out_* : one request per fix, east/north offsets in mm plus the origin flag,
//           taken on a rising edge with out_valid high and out_stall low.
//   The first fix after reset is latched as the origin and returns 0/0 with
//   is_origin_fix set; later fixes are measured from it. Out-of-range angles
//   are saturated before use. No antimeridian wrap.
//   Pipeline: from acceptance to out_valid a fix passes five front stages,
//   one cell per CORDIC step (CORDIC_STAGES, at most 32) and four back
//   stages (clamp, two-part product, rounding, sign/output).
//   Throughput: one fix per cycle unless stalled, the chain advancing as a whole.
//   Stall: while a result sits unclaimed in the output register and out_stall
//   is high, the whole chain holds and in_stall is raised; otherwise a new fix
//   is taken every cycle, even with a result waiting.
//   Reset (rst_n low, synchronous) empties the chain and forgets the origin.
module latlon_to_local_xy_projection import llxy_pkg::*; #(
  parameter int unsigned CORDIC_STAGES = 18
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  // only 32 rotation steps have table entries
  localparam int unsigned NCELL = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;

  logic en;

  logic    chain_v [NCELL+1];
  cordic_t chain_d [NCELL+1];

  // back-end stages
  logic        sc_v_r, e1_v_r, e2_v_r;
  logic [30:0] sc_cos_r;
  side_t       sc_side_r, e1_side_r, e2_side_r;
  logic [52:0] e1_lo_r, e1_hi_r;
  logic [35:0] e2_mag_r;
  logic [30:0] cos_nxt;
  logic [75:0] e_sum_nxt;

  logic out_valid_r;
  out_t out_data_r;

  // chain moves whenever the output register is free or being emptied
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  llxy_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .in_data  (in_data),
    .v_out    (chain_v[0]),
    .d_out    (chain_d[0])
  );

  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    llxy_cordic_cell #(.STAGE(g)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .v_in  (chain_v[g]),
      .d_in  (chain_d[g]),
      .v_out (chain_v[g+1]),
      .d_out (chain_d[g+1])
    );
  end

  // cosine clamped to [0, 1.0] in Q30
  always_comb begin
    if (chain_d[NCELL].x[31])                     cos_nxt = '0;
    else if (chain_d[NCELL].x > $signed({1'b0, ONE_Q30})) cos_nxt = ONE_Q30;
    else                                          cos_nxt = chain_d[NCELL].x[30:0];
  end

  // round_half_up(p * cos / 2^38), p split into two 22-bit halves
  assign e_sum_nxt = 76'({e1_hi_r, 22'd0}) + 76'(e1_lo_r) + (76'd1 << 37);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_v_r      <= 1'b0;
      e1_v_r      <= 1'b0;
      e2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      sc_v_r      <= chain_v[NCELL];
      e1_v_r      <= sc_v_r;
      e2_v_r      <= e1_v_r;
      out_valid_r <= e2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sc_cos_r  <= cos_nxt;
      sc_side_r <= chain_d[NCELL].side;

      e1_lo_r   <= 53'(sc_side_r.east_p[21:0]) * 53'(sc_cos_r);
      e1_hi_r   <= 53'(sc_side_r.east_p[43:22]) * 53'(sc_cos_r);
      e1_side_r <= sc_side_r;

      e2_mag_r  <= e_sum_nxt[73:38];
      e2_side_r <= e1_side_r;

      out_data_r.is_origin_fix <= e2_side_r.is_origin;
      if (e2_side_r.is_origin) begin
        out_data_r.east_mm  <= '0;
        out_data_r.north_mm <= '0;
      end else begin
        out_data_r.east_mm  <= e2_side_r.east_neg ? -$signed({1'b0, e2_mag_r})
                                                  : $signed({1'b0, e2_mag_r});
        out_data_r.north_mm <= e2_side_r.north_neg ? -$signed({1'b0, e2_side_r.north_mag})
                                                   : $signed({1'b0, e2_side_r.north_mag});
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // origin request carries zero offsets
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_origin_fix |-> (out_data.east_mm == '0 && out_data.north_mm == '0))
    else $error("origin result with non-zero offset");

  // input only held back by an unclaimed result
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with empty output register");

  // last back stage always lands in the output register
  assert property (@(posedge clk) disable iff (!rst_n)
    en && e2_v_r |=> out_valid)
    else $error("result lost between rounding stage and output");

endmodule

@@ rtl/llxy_cordic_cell.sv @@
// One rotation step of the cosine chain.
module llxy_cordic_cell import llxy_pkg::*; #(
  parameter int unsigned STAGE = 0
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    en,
  input  logic    v_in,
  input  cordic_t d_in,
  output logic    v_out,
  output cordic_t d_out
);

  logic    v_r;
  cordic_t d_r;
  cordic_t d_nxt;

  always_comb begin
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [31:0] at;
    dx = d_in.y >>> STAGE;
    dy = d_in.x >>> STAGE;
    at = $signed({2'b00, ATAN_Q30[STAGE]});
    d_nxt = d_in;
    if (!d_in.z[31]) begin
      d_nxt.x = d_in.x - dx;
      d_nxt.y = d_in.y + dy;
      d_nxt.z = d_in.z - at;
    end else begin
      d_nxt.x = d_in.x + dx;
      d_nxt.y = d_in.y - dy;
      d_nxt.z = d_in.z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign v_out = v_r;
  assign d_out = d_r;

endmodule

@@ rtl/llxy_front.sv @@
// Front end: saturation, origin latch, differences, scaling products and CORDIC angle.
module llxy_front import llxy_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    en,
  input  logic    in_valid,
  input  in_t     in_data,
  output logic    v_out,
  output cordic_t d_out
);

  logic accept;
  logic signed [30:0] lat_sat_nxt;
  logic signed [31:0] lon_sat_nxt;

  logic               origin_seen_r;
  logic signed [30:0] origin_lat_r;
  logic signed [31:0] origin_lon_r;

  // stage 0: saturated fix
  logic               s0_v_r, s0_org_r;
  logic signed [30:0] s0_lat_r;
  logic signed [31:0] s0_lon_r;

  // stage 1: signed differences and sum
  logic               s1_v_r, s1_org_r;
  logic signed [31:0] s1_dlat_r, s1_sum_r;
  logic signed [32:0] s1_dlon_r;
  logic signed [31:0] dlat_nxt, sum_nxt;
  logic signed [32:0] dlon_nxt;

  // stage 2: magnitudes
  logic        s2_v_r, s2_org_r, s2_nneg_r, s2_eneg_r;
  logic [30:0] s2_dlat_r, s2_sum_r;
  logic [31:0] s2_dlon_r;

  // stage 3: partial products
  logic        s3_v_r, s3_org_r, s3_nneg_r, s3_eneg_r;
  logic [62:0] s3_th_r;
  logic [50:0] s3_nlo_r, s3_nhi_r;
  logic [51:0] s3_elo_r, s3_ehi_r;

  // stage 4 sums
  logic [63:0] th_sum_nxt;
  logic [71:0] n_sum_nxt;
  logic [72:0] e_sum_nxt;

  logic    v_r;
  cordic_t d_r;

  assign accept = en & in_valid;

  always_comb begin
    if (in_data.latitude_e7 > LAT_MAX)       lat_sat_nxt = LAT_MAX;
    else if (in_data.latitude_e7 < -LAT_MAX) lat_sat_nxt = -LAT_MAX;
    else                                     lat_sat_nxt = in_data.latitude_e7;
    if (in_data.longitude_e7 > LON_MAX)       lon_sat_nxt = LON_MAX;
    else if (in_data.longitude_e7 < -LON_MAX) lon_sat_nxt = -LON_MAX;
    else                                      lon_sat_nxt = in_data.longitude_e7;
  end

  assign dlat_nxt = {s0_lat_r[30], s0_lat_r} - {origin_lat_r[30], origin_lat_r};
  assign sum_nxt  = {s0_lat_r[30], s0_lat_r} + {origin_lat_r[30], origin_lat_r};
  assign dlon_nxt = {s0_lon_r[31], s0_lon_r} - {origin_lon_r[31], origin_lon_r};

  assign th_sum_nxt = {1'b0, s3_th_r} + (64'd1 << 31);
  assign n_sum_nxt  = 72'({s3_nhi_r, 20'd0}) + 72'(s3_nlo_r) + (72'd1 << 35);
  assign e_sum_nxt  = 73'({s3_ehi_r, 20'd0}) + 73'(s3_elo_r) + (73'd1 << 27);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_seen_r <= 1'b0;
      s0_v_r        <= 1'b0;
      s1_v_r        <= 1'b0;
      s2_v_r        <= 1'b0;
      s3_v_r        <= 1'b0;
      v_r           <= 1'b0;
    end else begin
      if (accept) origin_seen_r <= 1'b1;
      if (en) begin
        s0_v_r <= in_valid;
        s1_v_r <= s0_v_r;
        s2_v_r <= s1_v_r;
        s3_v_r <= s2_v_r;
        v_r    <= s3_v_r;
      end
    end
  end

  // first fix after reset becomes the origin
  always_ff @(posedge clk) begin
    if (accept && !origin_seen_r) begin
      origin_lat_r <= lat_sat_nxt;
      origin_lon_r <= lon_sat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_lat_r <= lat_sat_nxt;
      s0_lon_r <= lon_sat_nxt;
      s0_org_r <= !origin_seen_r;

      s1_dlat_r <= dlat_nxt;
      s1_dlon_r <= dlon_nxt;
      s1_sum_r  <= sum_nxt;
      s1_org_r  <= s0_org_r;

      s2_dlat_r <= s1_dlat_r[31] ? 31'(-s1_dlat_r) : s1_dlat_r[30:0];
      s2_dlon_r <= s1_dlon_r[32] ? 32'(-s1_dlon_r) : s1_dlon_r[31:0];
      s2_sum_r  <= s1_sum_r[31]  ? 31'(-s1_sum_r)  : s1_sum_r[30:0];
      s2_nneg_r <= s1_dlat_r[31];
      s2_eneg_r <= s1_dlon_r[32];
      s2_org_r  <= s1_org_r;

      s3_th_r   <= 63'(s2_sum_r) * 63'(RAD_Q62);
      s3_nlo_r  <= 51'(s2_dlat_r) * 51'(MM_LO);
      s3_nhi_r  <= 51'(s2_dlat_r) * 51'(MM_HI);
      s3_elo_r  <= 52'(s2_dlon_r) * 52'(MM_LO);
      s3_ehi_r  <= 52'(s2_dlon_r) * 52'(MM_HI);
      s3_nneg_r <= s2_nneg_r;
      s3_eneg_r <= s2_eneg_r;
      s3_org_r  <= s2_org_r;

      d_r.x              <= CORDIC_GAIN_Q30;
      d_r.y              <= '0;
      d_r.z              <= $signed({1'b0, th_sum_nxt[62:32]});
      d_r.side.is_origin <= s3_org_r;
      d_r.side.north_neg <= s3_nneg_r;
      d_r.side.north_mag <= n_sum_nxt[70:36];
      d_r.side.east_neg  <= s3_eneg_r;
      d_r.side.east_p    <= e_sum_nxt[71:28];
    end
  end

  assign v_out = v_r;
  assign d_out = d_r;

endmodule

@@ bench/tb_latlon_to_local_xy_projection.sv @@
// Self-checking bench for the GPS fix to local east/north projection block.
module tb_latlon_to_local_xy_projection import llxy_pkg::*; ();

  // Block configuration and timing
  localparam int unsigned ROTATION_STEPS = 18;
  localparam int CHAIN_LATENCY = ROTATION_STEPS + 9;
  localparam int RANDOM_FIXES = 650;
  localparam int QUIET_LIMIT = 2000;     // cycles with no request moving on either side
  localparam int LONG_HOLD_CYCLES = 150;
  localparam int LONG_HOLD_AT = 250;     // results seen before the long hold-off starts

  // Arithmetic constants, worked out here independently of the RTL
  localparam longint unsigned MM_Q36 =
    (64'h0000_0032_43F6_A888 * 64'd6378137 + 64'd900000) / 64'd1800000;
  localparam longint unsigned RAD_Q62_UNIT =
    (64'hC90F_DAA2_2168_C234 + 64'd1800000000) / 64'd3600000000;
  localparam longint GAIN_Q30 = 64'sd652032874;
  localparam longint UNITY_Q30 = 64'sd1073741824;

  // The origin fix; chosen in range so that offsets of both signs can follow
  localparam longint HOME_LAT = 64'sd374221234;
  localparam longint HOME_LON = -64'sd1220841234;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  // Fixes waiting to be offered, and results the predictor has worked out
  in_t  fix_queue[$];
  out_t projected_q[$];

  // Predictor state: the latched origin
  bit     origin_set = 1'b0;
  longint origin_lat = 0;
  longint origin_lon = 0;

  int   errors = 0;
  logic receiver_holding = 1'b0;

  latlon_to_local_xy_projection #(.CORDIC_STAGES(ROTATION_STEPS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic longint saturate(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint unsigned magnitude(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  // round half up of a * b / 2^s, full 128-bit product
  function automatic longint unsigned round_mul_shift(longint unsigned a, longint unsigned b,
                                                      int unsigned s);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    prod = prod + (128'd1 << (s - 1));
    prod = prod >> s;
    return prod[63:0];
  endfunction

  // Rotation-mode CORDIC cosine in Q30; floor shifts, clamped to [0, 1]
  function automatic longint cos_q30(longint theta);
    longint x, y, z, dx, dy;
    x = GAIN_Q30;
    y = 0;
    z = theta;
    for (int i = 0; i < ROTATION_STEPS && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - longint'(ATAN_Q30[i]);
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + longint'(ATAN_Q30[i]);
      end
    end
    if (x < 0) x = 0;
    if (x > UNITY_Q30) x = UNITY_Q30;
    return x;
  endfunction

  // Works out the result for one accepted fix; latches the origin on the first
  function automatic out_t project_fix(in_t fix);
    longint lat, lon, dlat, dlon, lat_sum, cosine;
    longint unsigned mag, theta, east_q8;
    out_t r;
    lat = saturate(longint'(fix.latitude_e7), longint'(LAT_MAX));
    lon = saturate(longint'(fix.longitude_e7), longint'(LON_MAX));
    if (!origin_set) begin
      origin_set = 1'b1;
      origin_lat = lat;
      origin_lon = lon;
      r.east_mm = '0;
      r.north_mm = '0;
      r.is_origin_fix = 1'b1;
      return r;
    end
    dlat = lat - origin_lat;
    dlon = lon - origin_lon;
    lat_sum = lat + origin_lat;

    mag = round_mul_shift(magnitude(dlat), MM_Q36, 36);
    r.north_mm = 36'((dlat < 0) ? (64'd0 - mag) : mag);

    // mean latitude is half the sum, so |sum| scaled by half a radian unit
    theta = round_mul_shift(magnitude(lat_sum), RAD_Q62_UNIT, 32);
    cosine = cos_q30(longint'(theta));
    east_q8 = round_mul_shift(magnitude(dlon), MM_Q36, 28);
    mag = round_mul_shift(east_q8, longint'(cosine), 38);
    r.east_mm = 37'((dlon < 0) ? (64'd0 - mag) : mag);

    r.is_origin_fix = 1'b0;
    return r;
  endfunction

  function automatic in_t fix_at(longint lat, longint lon);
    in_t f;
    f.latitude_e7 = lat[30:0];
    f.longitude_e7 = lon[31:0];
    return f;
  endfunction

  // Appends a fix to the tail of the pending queue
  function automatic void add_fix(in_t f);
    fix_queue.insert(fix_queue.size(), f);
  endfunction

  // Appends a predicted result to the tail of the expected queue
  function automatic void add_projection(out_t r);
    projected_q.insert(projected_q.size(), r);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers queued fixes, draws a random gap after each request
  // ---------------------------------------------------------------------------
  int items_sent = 0;
  int gap_left = 0;

  always @(posedge clk) begin : drv
    logic next_valid;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      next_valid = in_valid;
      if (in_valid && !in_stall) begin
        add_projection(project_fix(in_data));
        items_sent++;
        // every other block of 60 requests goes back to back; likewise
        // while the receiver holds off, so that the chain fills up
        if (receiver_holding || ((items_sent / 60) % 2 == 1))
          gap_left = 0;
        else
          gap_left = $urandom_range(0, 6);
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (fix_queue.size() > 0) begin
          in_data <= fix_queue.pop_front();
          next_valid = 1'b1;
        end
      end
      in_valid <= next_valid;   // one assignment per edge
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: claims results, checks them against the oldest prediction and
  // stalls for a random spell after each; one long hold-off part way through
  // ---------------------------------------------------------------------------
  int results_seen = 0;
  int stall_left = 0;
  int hold_left = 0;

  always @(posedge clk) begin : mon
    out_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      receiver_holding <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (projected_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: expected none, got east %0d north %0d origin %0b",
                   $time, out_data.east_mm, out_data.north_mm, out_data.is_origin_fix);
        end else begin
          want = projected_q.pop_front();
          if (out_data.east_mm !== want.east_mm) begin
            errors++;
            $display("%0t: east_mm mismatch: expected %0d, got %0d",
                     $time, want.east_mm, out_data.east_mm);
          end
          if (out_data.north_mm !== want.north_mm) begin
            errors++;
            $display("%0t: north_mm mismatch: expected %0d, got %0d",
                     $time, want.north_mm, out_data.north_mm);
          end
          if (out_data.is_origin_fix !== want.is_origin_fix) begin
            errors++;
            $display("%0t: is_origin_fix mismatch: expected %0b, got %0b",
                     $time, want.is_origin_fix, out_data.is_origin_fix);
          end
        end
        // blocks of 50 results alternate between random stalls and none
        stall_left = ((results_seen / 50) % 2 == 1) ? 0 : $urandom_range(0, 6);
        if (results_seen == LONG_HOLD_AT) hold_left = LONG_HOLD_CYCLES;
      end else if (stall_left > 0) begin
        stall_left--;
      end
      if (hold_left > 0) hold_left--;
      out_stall <= (stall_left > 0) || (hold_left > 0);
      receiver_holding <= (hold_left > 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: too long with no request moving means the block has hung
  // ---------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("TB_ERROR");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    longint lat, lon;
    int pick;

    // Directed: origin first, then the extremes and saturation edges
    add_fix(fix_at(HOME_LAT, HOME_LON));                // latched as origin
    add_fix(fix_at(HOME_LAT, HOME_LON));                // zero offset
    add_fix(fix_at(900000000, 1800000000));            // at the limits
    add_fix(fix_at(-900000000, -1800000000));
    add_fix(fix_at(900000001, 1800000001));            // just past: saturated
    add_fix(fix_at(-900000001, -1800000001));
    add_fix(fix_at(64'sd1073741823, 64'sd2147483647));  // field maxima
    add_fix(fix_at(-64'sd1073741824, -64'sd2147483648)); // field minima
    add_fix(fix_at(899999999, 1799999999));
    add_fix(fix_at(-HOME_LAT, HOME_LON + 1));           // mean latitude zero
    add_fix(fix_at(HOME_LAT + 1, HOME_LON - 1));        // single-unit steps
    add_fix(fix_at(HOME_LAT - 1, HOME_LON + 1));
    add_fix(fix_at(0, 0));
    add_fix(fix_at(1, -1));
    add_fix(fix_at(899000000, HOME_LON + 100000000));   // near the pole, small cosine
    add_fix(fix_at(-900000000, HOME_LON - 10000000));   // most negative mean latitude
    add_fix(fix_at(HOME_LAT, 1800000000));              // widest east span
    add_fix(fix_at(-900000000, HOME_LON));              // widest north span

    // Random: mostly realistic fixes around the origin, the rest spread wide
    for (int n = 0; n < RANDOM_FIXES; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        // within a few km of the origin
        lat = HOME_LAT + longint'($urandom_range(0, 400000)) - 200000;
        lon = HOME_LON + longint'($urandom_range(0, 400000)) - 200000;
      end else if (pick < 60) begin
        // within some degrees
        lat = HOME_LAT + longint'($urandom_range(0, 100000000)) - 50000000;
        lon = HOME_LON + longint'($urandom_range(0, 100000000)) - 50000000;
      end else if (pick < 82) begin
        // anywhere on the globe
        lat = longint'($urandom_range(0, 1800000000)) - 900000000;
        lon = longint'($urandom_range(0, 32'd3600000000)) - 1800000000;
      end else if (pick < 94) begin
        // raw bit patterns, out-of-range values included
        lat = longint'($urandom());
        lon = longint'($urandom());
      end else begin
        // around the saturation limits
        case ($urandom_range(0, 3))
          0: lat = 900000000;
          1: lat = -900000000;
          2: lat = 900000000 + longint'($urandom_range(0, 2));
          default: lat = -900000000 - longint'($urandom_range(0, 2));
        endcase
        case ($urandom_range(0, 3))
          0: lon = 1800000000;
          1: lon = -1800000000;
          2: lon = 1800000000 + longint'($urandom_range(0, 2));
          default: lon = -1800000000 - longint'($urandom_range(0, 2));
        endcase
      end
      add_fix(fix_at(lat, lon));
    end

    // Reset held low from the start, then released for good
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: every fix offered and every prediction matched
    while (fix_queue.size() != 0 || in_valid || projected_q.size() != 0)
      @(posedge clk);
    // let any stray result surface
    repeat (CHAIN_LATENCY + 8) @(posedge clk);

    if (errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
